### src/sfa_pkg.sv
// Package for the shared frame allocator: sizes, codes and request/response types.
package sfa_pkg;

    // Pool geometry.
    localparam int FRAMES     = 512;
    localparam int PAGE_BYTES = 128;
    localparam int MAX_OWNERS = 4;

    // Field widths of the request and response.
    localparam int OFF_W       = 17;
    localparam int ID_W        = 8;
    localparam int PG_W        = 12;
    localparam int FRAME_OUT_W = 9;
    localparam int COUNT_OUT_W = 3;

    // Derived sizes. PAGE_BYTES is a power of two, so the frame is a shift.
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int FNUM_W     = OFF_W - PAGE_SHIFT;
    localparam int ROW_FRAMES = 32;
    localparam int COL_W      = $clog2(ROW_FRAMES);
    localparam int USED_ROWS  = (FRAMES + ROW_FRAMES - 1) / ROW_FRAMES;
    localparam int ROW_W      = (USED_ROWS > 1) ? $clog2(USED_ROWS) : 1;
    localparam int FIDX_W     = ROW_W + COL_W;
    localparam int FRAME_W    = $clog2(FRAMES);
    localparam int CNT_W      = $clog2(MAX_OWNERS + 1);
    localparam int SLOT_W     = (MAX_OWNERS > 1) ? $clog2(MAX_OWNERS) : 1;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_ADD     = 2'd2,
        OP_QUERY   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_FREE   = 3'd1,
        ST_RANGE     = 3'd2,
        ST_FULL      = 3'd3,
        ST_PAGE      = 3'd4,
        ST_NOT_OWNED = 3'd5
    } status_t;

    typedef struct packed {
        op_t               operation;
        logic [OFF_W-1:0]  offset;
        logic [ID_W-1:0]   owner_id;
        logic [PG_W-1:0]   vpage;
    } sfa_req_t;

    typedef struct packed {
        status_t                status;
        logic [FRAME_OUT_W-1:0] frame;
        logic                   used;
        logic [COUNT_OUT_W-1:0] owner_count;
        logic [PG_W-1:0]        page_of_owners;
    } sfa_rsp_t;

endpackage

### src/shared_frame_allocator.sv
// Shared swap frame allocator: first-fit frame allocation with per-frame owner lists.
//
// Requests arrive on req_valid/req_ready/req and responses leave on
// rsp_valid/rsp_ready/rsp; every request yields exactly one response.
// The block works on one request at a time and drops req_ready from the
// cycle after acceptance until its response is loaded into the output
// register; the response shows up in the cycle the block is ready again.
// Query and add read the frame and evaluate it; allocate first picks a row and
// a column (or reports that no frame is free), an out-of-range request goes
// straight to the output state, and release uses a single id comparator that
// walks the owner list one slot per cycle and then closes the gap one slot per cycle.
// Allocate searches a summary of full 32-frame rows, then the chosen row.
// Reset clears the controller and the per-row valid bits of the used-flag
// and owner-count stores, so every frame reads as free with no owners at
// once; no clearing pass is needed. Owner ids and pages are undefined
// until written. A response that the receiver stalls stays in the output
// register; the block may finish the next request meanwhile and holds it
// until the output register frees up.
module shared_frame_allocator
    import sfa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  sfa_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output sfa_rsp_t rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC_ROW,
        S_ALLOC_COL,
        S_READ,
        S_EVAL,
        S_SCAN,
        S_SHIFT,
        S_OUT
    } state_t;

    typedef logic [ROW_FRAMES-1:0]             used_row_t;
    typedef logic [ROW_FRAMES-1:0][CNT_W-1:0]  cnt_row_t;
    typedef logic [MAX_OWNERS-1:0][ID_W-1:0]   id_row_t;

    // Builds a response that reports a frame; a frame without owners shows page zero.
    function automatic sfa_rsp_t report(status_t st, logic [FIDX_W-1:0] f, logic u,
                                        logic [CNT_W-1:0] n, logic [PG_W-1:0] p);
        sfa_rsp_t r;
        r.status         = st;
        r.frame          = FRAME_OUT_W'(f);
        r.used           = u;
        r.owner_count    = COUNT_OUT_W'(n);
        r.page_of_owners = (n != '0) ? p : '0;
        return r;
    endfunction

    // Control and working registers.
    state_t                state_reg, state_next;
    op_t                   op_reg, op_next;
    logic [ID_W-1:0]       id_reg, id_next;
    logic [PG_W-1:0]       pg_reg, pg_next;
    logic [FIDX_W-1:0]     fidx_reg, fidx_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    id_row_t               slots_reg, slots_next;
    sfa_rsp_t              res_reg, res_next;
    sfa_rsp_t              rsp_reg, rsp_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    logic [USED_ROWS-1:0]  used_vld_reg, used_vld_next;
    logic [USED_ROWS-1:0]  cnt_vld_reg, cnt_vld_next;
    logic [USED_ROWS-1:0]  full_reg, full_next;

    // Storage. Used flags and owner counts are kept 32 frames to a row.
    used_row_t             used_mem [USED_ROWS];
    cnt_row_t              cnt_mem  [USED_ROWS];
    logic [PG_W-1:0]       page_mem [FRAMES];
    id_row_t               id_mem   [FRAMES];

    used_row_t             used_rd_reg;
    cnt_row_t              cnt_rd_reg;
    logic [PG_W-1:0]       page_rd_reg;
    id_row_t               id_rd_reg;

    logic                  used_we, cnt_we, page_we, id_we;
    used_row_t             used_wdata;
    cnt_row_t              cnt_wdata;
    logic [PG_W-1:0]       page_wdata;
    id_row_t               id_wdata;

    logic [ROW_W-1:0]      rd_row;
    logic [ROW_W-1:0]      row_cur;
    logic [COL_W-1:0]      col_cur;
    logic [FRAME_W-1:0]    frame_addr;

    used_row_t             used_row_cur;
    cnt_row_t              cnt_row_cur;
    used_row_t             col_mask;
    used_row_t             free_cols;
    used_row_t             new_used_row;
    logic                  used_b;
    logic [CNT_W-1:0]      n_cur;
    logic [CNT_W-1:0]      idx_inc;

    logic                  row_found;
    logic [ROW_W-1:0]      alloc_row;
    logic [COL_W-1:0]      alloc_col;
    logic [FNUM_W-1:0]     fnum;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign row_cur    = fidx_reg[FIDX_W-1:COL_W];
    assign col_cur    = fidx_reg[COL_W-1:0];
    assign frame_addr = FRAME_W'(fidx_reg);
    assign rd_row     = (state_reg == S_ALLOC_ROW) ? alloc_row : row_cur;
    assign fnum       = req.offset[OFF_W-1:PAGE_SHIFT];
    assign idx_inc    = idx_reg + CNT_W'(1);

    // A row that was never written reads as all free, no owners.
    assign used_row_cur = used_vld_reg[row_cur] ? used_rd_reg : '0;
    assign cnt_row_cur  = cnt_vld_reg[row_cur] ? cnt_rd_reg : '0;
    assign used_b       = used_row_cur[col_cur];
    assign n_cur        = cnt_row_cur[col_cur];

    // Columns of the current row that hold real frames.
    always_comb
    begin
        for (int c = 0; c < ROW_FRAMES; c++)
        begin
            col_mask[c] = (32'({row_cur, COL_W'(c)}) < 32'(FRAMES));
        end
    end

    assign free_cols = ~used_row_cur & col_mask;

    // Lowest row that still has a free frame.
    always_comb
    begin
        row_found = 1'b0;
        alloc_row = '0;
        for (int i = USED_ROWS - 1; i >= 0; i--)
        begin
            if (!full_reg[i])
            begin
                row_found = 1'b1;
                alloc_row = ROW_W'(i);
            end
        end
    end

    // Lowest free column of the row read for allocation.
    always_comb
    begin
        alloc_col = '0;
        for (int c = ROW_FRAMES - 1; c >= 0; c--)
        begin
            if (free_cols[c])
            begin
                alloc_col = COL_W'(c);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        id_next        = id_reg;
        pg_next        = pg_reg;
        fidx_next      = fidx_reg;
        idx_next       = idx_reg;
        slots_next     = slots_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        used_vld_next  = used_vld_reg;
        cnt_vld_next   = cnt_vld_reg;
        full_next      = full_reg;

        used_we      = 1'b0;
        cnt_we       = 1'b0;
        page_we      = 1'b0;
        id_we        = 1'b0;
        new_used_row = used_row_cur;
        used_wdata   = used_row_cur;
        cnt_wdata    = cnt_row_cur;
        page_wdata   = pg_reg;
        id_wdata     = slots_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next = req.operation;
                    id_next = req.owner_id;
                    pg_next = req.vpage;
                    if (req.operation == OP_ALLOC)
                    begin
                        state_next = S_ALLOC_ROW;
                    end
                    else if (32'(fnum) >= 32'(FRAMES))
                    begin
                        res_next   = report(ST_RANGE, '0, 1'b0, '0, '0);
                        state_next = S_OUT;
                    end
                    else
                    begin
                        fidx_next  = FIDX_W'(fnum);
                        state_next = S_READ;
                    end
                end
            end

            S_ALLOC_ROW:
            begin
                if (row_found)
                begin
                    fidx_next  = {alloc_row, COL_W'(0)};
                    state_next = S_ALLOC_COL;
                end
                else
                begin
                    res_next   = report(ST_NO_FREE, '0, 1'b0, '0, '0);
                    state_next = S_OUT;
                end
            end

            S_ALLOC_COL:
            begin
                // Mark the frame used, then report it like a query.
                new_used_row            = used_row_cur;
                new_used_row[alloc_col] = 1'b1;
                used_we                 = 1'b1;
                used_wdata              = new_used_row;
                used_vld_next[row_cur]  = 1'b1;
                full_next[row_cur]      = &(new_used_row | ~col_mask);
                fidx_next               = {row_cur, alloc_col};
                state_next              = S_READ;
            end

            S_READ:
            begin
                state_next = S_EVAL;
            end

            S_EVAL:
            begin
                state_next = S_OUT;
                case (op_reg)
                    OP_ADD:
                    begin
                        if (n_cur >= CNT_W'(MAX_OWNERS))
                        begin
                            res_next = report(ST_FULL, fidx_reg, used_b, n_cur, page_rd_reg);
                        end
                        else if ((n_cur != '0) && (page_rd_reg != pg_reg))
                        begin
                            res_next = report(ST_PAGE, fidx_reg, used_b, n_cur, page_rd_reg);
                        end
                        else
                        begin
                            id_wdata                     = id_rd_reg;
                            id_wdata[SLOT_W'(n_cur)]     = id_reg;
                            id_we                        = 1'b1;
                            page_we                      = 1'b1;
                            page_wdata                   = pg_reg;
                            cnt_wdata                    = cnt_row_cur;
                            cnt_wdata[col_cur]           = n_cur + CNT_W'(1);
                            cnt_we                       = 1'b1;
                            cnt_vld_next[row_cur]        = 1'b1;
                            res_next = report(ST_OK, fidx_reg, used_b,
                                              n_cur + CNT_W'(1), pg_reg);
                        end
                    end
                    OP_RELEASE:
                    begin
                        slots_next = id_rd_reg;
                        idx_next   = '0;
                        state_next = S_SCAN;
                    end
                    default:
                    begin
                        res_next = report(ST_OK, fidx_reg, used_b, n_cur, page_rd_reg);
                    end
                endcase
            end

            S_SCAN:
            begin
                // One owner slot compared per cycle.
                if (idx_reg >= n_cur)
                begin
                    res_next   = report(ST_NOT_OWNED, fidx_reg, used_b, n_cur, page_rd_reg);
                    state_next = S_OUT;
                end
                else if (slots_reg[SLOT_W'(idx_reg)] == id_reg)
                begin
                    state_next = S_SHIFT;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end

            S_SHIFT:
            begin
                if (idx_inc < n_cur)
                begin
                    slots_next[SLOT_W'(idx_reg)] = slots_reg[SLOT_W'(idx_inc)];
                    idx_next                     = idx_inc;
                end
                else
                begin
                    id_we                 = 1'b1;
                    id_wdata              = slots_reg;
                    cnt_wdata             = cnt_row_cur;
                    cnt_wdata[col_cur]    = n_cur - CNT_W'(1);
                    cnt_we                = 1'b1;
                    cnt_vld_next[row_cur] = 1'b1;
                    if (n_cur == CNT_W'(1))
                    begin
                        // Last owner left: the frame becomes free.
                        new_used_row          = used_row_cur;
                        new_used_row[col_cur] = 1'b0;
                        used_we               = 1'b1;
                        used_wdata            = new_used_row;
                        used_vld_next[row_cur] = 1'b1;
                        full_next[row_cur]    = 1'b0;
                        res_next = report(ST_OK, fidx_reg, 1'b0, '0, page_rd_reg);
                    end
                    else
                    begin
                        res_next = report(ST_OK, fidx_reg, used_b,
                                          n_cur - CNT_W'(1), page_rd_reg);
                    end
                    state_next = S_OUT;
                end
            end

            S_OUT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_ALLOC;
            id_reg        <= '0;
            pg_reg        <= '0;
            fidx_reg      <= '0;
            idx_reg       <= '0;
            slots_reg     <= '0;
            res_reg       <= '0;
            rsp_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            used_vld_reg  <= '0;
            cnt_vld_reg   <= '0;
            full_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            id_reg        <= id_next;
            pg_reg        <= pg_next;
            fidx_reg      <= fidx_next;
            idx_reg       <= idx_next;
            slots_reg     <= slots_next;
            res_reg       <= res_next;
            rsp_reg       <= rsp_next;
            rsp_valid_reg <= rsp_valid_next;
            used_vld_reg  <= used_vld_next;
            cnt_vld_reg   <= cnt_vld_next;
            full_reg      <= full_next;
        end
    end

    // Row stores: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (used_we)
        begin
            used_mem[row_cur] <= used_wdata;
        end
        if (cnt_we)
        begin
            cnt_mem[row_cur] <= cnt_wdata;
        end
        used_rd_reg <= used_mem[rd_row];
        cnt_rd_reg  <= cnt_mem[rd_row];
    end

    // Per-frame stores: page and owner list.
    always_ff @(posedge clk)
    begin
        if (page_we)
        begin
            page_mem[frame_addr] <= page_wdata;
        end
        if (id_we)
        begin
            id_mem[frame_addr] <= id_wdata;
        end
        page_rd_reg <= page_mem[frame_addr];
        id_rd_reg   <= id_mem[frame_addr];
    end

endmodule

### src/sfa_checker.sv
// Port-level checker for the shared frame allocator, bound to the top level.
module sfa_checker
    import sfa_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     req_valid,
    input logic     req_ready,
    input sfa_req_t req,
    input logic     rsp_valid,
    input logic     rsp_ready,
    input sfa_rsp_t rsp
);

    // A stalled response holds its value.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // Only one request is in work at a time.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in work");

    // Failed allocation and out-of-range requests report nothing else.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == ST_NO_FREE || rsp.status == ST_RANGE)
        |-> rsp.frame == '0 && !rsp.used && rsp.owner_count == '0
            && rsp.page_of_owners == '0)
        else $error("error response carries frame data");

    // A frame without owners shows no page, and the list never overflows.
    a_owner_page: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.owner_count != '0 || rsp.page_of_owners == '0)
            && 32'(rsp.owner_count) <= 32'(MAX_OWNERS))
        else $error("owner count and page disagree");

endmodule

bind shared_frame_allocator sfa_checker u_sfa_checker (.*);
